@@ hw/rtl/fwdf_pkg.sv @@
// ----------------------------------------------------------------------------
// fwdf_pkg
// Shared types and constants for the fixed-width decimal digit formatter.
// ----------------------------------------------------------------------------
package fwdf_pkg;

    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 4;
    localparam int COLUMN_W   = 8;
    localparam int ROW_W      = 6;
    localparam int CODE_W     = 6;
    localparam int BCD_W      = 4;
    localparam int MAX_DIGITS = 10;
    localparam int DIG_IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);

    localparam logic [CODE_W-1:0]   SPACE_CODE     = CODE_W'(32);
    localparam logic [CODE_W-1:0]   ZERO_CODE      = CODE_W'(48);
    localparam logic [CODE_W-1:0]   NINE_CODE      = CODE_W'(57);
    localparam logic [COLUMN_W-1:0] SPACING_SMALL  = COLUMN_W'(6);
    localparam logic [COLUMN_W-1:0] SPACING_TALL   = COLUMN_W'(8);

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [COUNT_W-1:0]  digit_count;
        logic [COLUMN_W-1:0] start_column;
        logic [ROW_W-1:0]    row;
        logic                font_tall;
    } t_fwdf_in;

    typedef struct packed {
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row_out;
        logic [CODE_W-1:0]   char_code;
        logic                last;
    } t_fwdf_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_fwdf_state;

endpackage

@@ hw/rtl/fwdf_cell.sv @@
// ----------------------------------------------------------------------------
// fwdf_cell
// One BCD digit of the shift-and-add-3 converter: correct, then shift left,
// taking the carry from the cell below and passing its own up.
// ----------------------------------------------------------------------------
module fwdf_cell
    import fwdf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_clear,
    input  logic             i_shift,
    input  logic             i_bit_in,
    output logic             o_bit_out,
    output logic [BCD_W-1:0] o_digit
);

    logic [BCD_W-1:0] r_digit;
    logic [BCD_W-1:0] n_digit;
    logic [BCD_W-1:0] w_adj;

    // add three to a digit of five or more before it doubles
    assign w_adj     = (r_digit >= BCD_W'(5)) ? r_digit + BCD_W'(3) : r_digit;
    assign o_bit_out = w_adj[BCD_W-1];
    assign o_digit   = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_clear) begin
            n_digit = '0;
        end else if (i_shift) begin
            n_digit = {w_adj[BCD_W-2:0], i_bit_in};
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

@@ hw/rtl/fixed_width_decimal_digit_formatter.sv @@
// ----------------------------------------------------------------------------
// fixed_width_decimal_digit_formatter
// Converts a 32-bit unsigned value to decimal and emits one character
// transaction per shown position, with leading zeros blanked to spaces.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one number with
//   its digit count, start column, row and font flag. Output channel
//   (o_out_valid / i_out_stall / o_out) carries one character per position,
//   most significant first, with last set on the final one.
//   A number passes through a load cycle, bit-serial conversion of all 32
//   value bits through a row of ten BCD digit cells, then emission of one
//   character per cycle while the receiver does not stall, N characters in
//   all, N being the saturated digit count (at most ten). A count of zero
//   leaves the block in idle with no output.
//   o_in_stall is high while a number is in work; a new number is taken as
//   soon as the last character sits in the output register.
//   When the receiver stalls, the output register holds its character and
//   emission pauses. Reset clears the state machine and the output valid.
// ----------------------------------------------------------------------------
module fixed_width_decimal_digit_formatter
    import fwdf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_fwdf_in  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_fwdf_out o_out
);

    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(VALUE_W - 1);

    t_fwdf_state r_state, n_state;

    logic [VALUE_W-1:0]   r_value;
    logic [BIT_CNT_W-1:0] r_bit_cnt;
    logic [COUNT_W-1:0]   r_count;
    logic [COUNT_W-1:0]   r_pos;
    logic [COLUMN_W-1:0]  r_column;
    logic [ROW_W-1:0]     r_row;
    logic                 r_tall;
    logic                 r_showing;
    logic                 r_out_valid;
    t_fwdf_out            r_out;

    logic                 w_accept;
    logic                 w_shift;
    logic                 w_load;
    logic [COUNT_W-1:0]   w_count_sat;
    logic [COUNT_W-1:0]   w_idx_full;
    logic [DIG_IDX_W-1:0] w_idx;
    logic [BCD_W-1:0]     w_digit;
    logic                 w_is_last;
    logic                 w_blank;
    logic [CODE_W-1:0]    w_code;

    logic [BCD_W-1:0]     w_digits [MAX_DIGITS];
    logic                 w_carry  [MAX_DIGITS];

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_count_sat = (i_in.digit_count > COUNT_W'(MAX_DIGITS)) ?
                         COUNT_W'(MAX_DIGITS) : i_in.digit_count;

    // digit cell chain, carry moves from the least significant cell upward
    assign w_carry[0] = r_value[VALUE_W-1];

    for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
        if (k < MAX_DIGITS - 1) begin : g_mid
            fwdf_cell u_cell (
                .i_clk     (i_clk),
                .i_clear   (w_accept),
                .i_shift   (w_shift),
                .i_bit_in  (w_carry[k]),
                .o_bit_out (w_carry[k+1]),
                .o_digit   (w_digits[k])
            );
        end else begin : g_top
            // carry out of the top digit is the part beyond the shown digits: drop
            fwdf_cell u_cell (
                .i_clk     (i_clk),
                .i_clear   (w_accept),
                .i_shift   (w_shift),
                .i_bit_in  (w_carry[k]),
                .o_bit_out (),
                .o_digit   (w_digits[k])
            );
        end
    end

    // position pos shows decimal digit count-1-pos
    assign w_idx_full = r_count - COUNT_W'(1) - r_pos;
    assign w_idx      = w_idx_full[DIG_IDX_W-1:0];
    assign w_digit    = w_digits[w_idx];
    assign w_is_last  = (r_pos == r_count - COUNT_W'(1));
    assign w_blank    = !r_showing && !w_is_last && (w_digit == '0);
    assign w_code     = w_blank ? SPACE_CODE : ZERO_CODE + CODE_W'(w_digit);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (w_count_sat != '0)) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_bit_cnt == BIT_LAST) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_load && w_is_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_shift    = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_CONV: w_shift    = 1'b1;
            ST_EMIT: w_load     = !r_out_valid || !i_out_stall;
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value   <= i_in.value;
            r_bit_cnt <= '0;
            r_count   <= w_count_sat;
            r_pos     <= '0;
            r_column  <= i_in.start_column;
            r_row     <= i_in.row;
            r_tall    <= i_in.font_tall;
            r_showing <= 1'b0;
        end else if (w_shift) begin
            r_value   <= {r_value[VALUE_W-2:0], 1'b0};
            r_bit_cnt <= r_bit_cnt + BIT_CNT_W'(1);
        end else if (w_load) begin
            r_pos     <= r_pos + COUNT_W'(1);
            r_column  <= r_column + (r_tall ? SPACING_TALL : SPACING_SMALL);
            r_showing <= !w_blank;
        end
        if (w_load) begin
            r_out.column    <= r_column;
            r_out.row_out   <= r_row;
            r_out.char_code <= w_code;
            r_out.last      <= w_is_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ------------------------------------------------------------------------
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.char_code == SPACE_CODE) ||
                        ((o_out.char_code >= ZERO_CODE) && (o_out.char_code <= NINE_CODE)))
        else $error("character code outside space and digits");

    a_last_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.last |-> o_out.char_code != SPACE_CODE)
        else $error("final character blanked");

    a_conv_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) && (r_bit_cnt == BIT_LAST) |=> r_state == ST_EMIT)
        else $error("conversion did not finish after all bits");

    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_in.digit_count == '0) |=> (r_state == ST_IDLE) && !w_load)
        else $error("zero digit count started work");

    a_no_blank_after_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && r_showing |-> !w_blank)
        else $error("space emitted after a shown digit");

endmodule
